// ===== rtl/fp32_pkg.sv =====
// fp32_pkg: shared constants for the truncating single-precision adder.
// No dependencies.
`timescale 1ns / 1ps
package fp32_pkg;
    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFC0;
endpackage

// ===== rtl/fp32_lzc.sv =====
// fp32_lzc: leading-zero count of a 32-bit word (combinational).
// Depends on nothing.
`timescale 1ns / 1ps
module fp32_lzc
(
    input  logic [31:0] value,
    output logic [5:0]  count
);
    logic [15:0] v16;
    logic [7:0]  v8;
    logic [3:0]  v4;
    logic [1:0]  v2;
    logic        z16, z8, z4, z2, z1;

    always_comb
    begin
        z16 = (value[31:16] == 16'd0);
        v16 = z16 ? value[15:0] : value[31:16];
        z8  = (v16[15:8] == 8'd0);
        v8  = z8 ? v16[7:0] : v16[15:8];
        z4  = (v8[7:4] == 4'd0);
        v4  = z4 ? v8[3:0] : v8[7:4];
        z2  = (v4[3:2] == 2'd0);
        v2  = z2 ? v4[1:0] : v4[3:2];
        z1  = ~v2[1];
        if (value == 32'd0)
            count = 6'd32;
        else
            count = {1'b0, z16, z8, z4, z2, z1};
    end
endmodule

// ===== rtl/fp32_adder_truncating.sv =====
// fp32_adder_truncating: pipelined truncating single-precision adder.
// Depends on fp32_pkg and fp32_lzc.
//
// Usage:
//   s_axis_* carries one request: tdata = {operand_b, operand_a}
//   (operand_a in bits 31:0). m_axis_* returns tdata = sum_bits.
//   Four register stages: order/special-case, align/subtract,
//   normalize, pack; v4_reg, the last valid bit, is m_axis_tvalid.
//   One request is taken every cycle while m_axis_tready is high.
//   When the receiver holds m_axis_tready low with a result
//   waiting, a stage holding a request freezes only if every later
//   stage is full (bubbles collapse); s_axis_tready drops if all are.
//   Reset clears all valid bits; payload registers are not reset.
//   No rounding, no inf/NaN/denormal handling; exponent arithmetic
//   wraps modulo 2^32 as in the behavioral description.
`timescale 1ns / 1ps
module fp32_adder_truncating
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] sum_bits
);
    import fp32_pkg::*;

    // stage enables: a stage loads when it is empty or its content moves on
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign en4 = ~v4_reg | m_axis_tready;
    assign en3 = ~v3_reg | en4;
    assign en2 = ~v2_reg | en3;
    assign en1 = ~v1_reg | en2;
    assign s_axis_tready = en1;

    // ---- stage 1: order operands, flag special cases
    logic [31:0] a, b, big_next, small_next;
    logic        opp_next, cancel_next;
    logic [31:0] big_reg, small_reg;
    logic        opp_reg, cancel_reg;

    always_comb
    begin
        a = s_axis_tdata[31:0];
        b = s_axis_tdata[63:32];
        opp_next    = a[31] ^ b[31];
        cancel_next = opp_next && (a[30:0] == b[30:0]);
        if (b[30:0] > a[30:0])
        begin
            big_next = b; small_next = a;
        end
        else
        begin
            big_next = a; small_next = b;
        end
    end

    // ---- stage 2: align and add/subtract
    logic [31:0] dexp, bigf, smallf, sh, frac_next;
    logic        near_next;
    logic [31:0] frac2_reg, big2_reg;
    logic        near2_reg, cancel2_reg, zero2_reg;

    always_comb
    begin
        sh = 32'd0;
        dexp = {24'd0, big_reg[30:23]} - {24'd0, small_reg[30:23]};
        near_next = (dexp[31:1] == 31'd0) && opp_reg;
        if (near_next)
        begin
            bigf   = {big_reg[23:0], 8'd0} | SIGN_MASK;
            smallf = {small_reg[23:0], 8'd0} | SIGN_MASK;
            if (dexp[0])
                smallf = smallf >> 1;
            frac_next = bigf - smallf;
        end
        else
        begin
            bigf   = ({big_reg[23:0], 8'd0} | SIGN_MASK) >> 1;
            smallf = ({small_reg[23:0], 8'd0} | SIGN_MASK) >> 1;
            sh = (dexp >= 32'd32) ? 32'd0 : (smallf >> dexp[4:0]);
            sh = sh & ALIGN_MASK;
            frac_next = opp_reg ? bigf - sh : bigf + sh;
        end
    end

    // ---- stage 3: normalize
    logic [5:0]  lz;
    logic [31:0] frac3_next, ex3_next;
    logic [31:0] frac3_reg, ex3_reg, big3_reg;
    logic        cancel3_reg, zero3_reg;

    fp32_lzc u_lzc
    (
        .value (frac2_reg),
        .count (lz)
    );

    always_comb
    begin
        ex3_next = {24'd0, big2_reg[30:23]};
        if (near2_reg)
        begin
            frac3_next = (lz[5] ? 32'd0 : (frac2_reg << lz[4:0])) << 1;
            ex3_next   = ex3_next - {26'd0, lz};
        end
        else if (frac2_reg[31])
        begin
            frac3_next = frac2_reg << 1;
            ex3_next   = ex3_next + 32'd1;
        end
        else if (frac2_reg[30])
            frac3_next = frac2_reg << 2;
        else
        begin
            frac3_next = frac2_reg << 3;
            ex3_next   = ex3_next - 32'd1;
        end
    end

    // ---- stage 4: pack
    logic [31:0] res_next, res_reg;

    always_comb
    begin
        if (cancel3_reg)
            res_next = 32'd0;
        else if (zero3_reg)
            res_next = big3_reg;
        else
            res_next = (big3_reg & SIGN_MASK) | (ex3_reg << 23) | (frac3_reg >> 9);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            big_reg    <= big_next;
            small_reg  <= small_next;
            opp_reg    <= opp_next;
            cancel_reg <= cancel_next;
        end
        if (en2)
        begin
            frac2_reg   <= frac_next;
            big2_reg    <= big_reg;
            near2_reg   <= near_next;
            cancel2_reg <= cancel_reg;
            zero2_reg   <= (small_reg[30:0] == 31'd0);
        end
        if (en3)
        begin
            frac3_reg   <= frac3_next;
            ex3_reg     <= ex3_next;
            big3_reg    <= big2_reg;
            cancel3_reg <= cancel2_reg;
            zero3_reg   <= zero2_reg;
        end
        if (en4)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = res_reg;

    // a stalled result must hold
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // a full, stalled pipeline refuses input
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && v4_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline full");
    // accepted request reaches stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted request lost");
endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for fp32_adder_truncating.
// Depends on fp32_pkg and the adder RTL; predicts each sum in SystemVerilog.
`timescale 1ns / 1ps
module tb;
    import fp32_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] operand_a, [63:32] operand_b
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] sum_bits

    fp32_adder_truncating dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [31:0] sum_queue[$];
    int          errors;
    int          sums_checked;
    int          cycles;
    bit          src_idle_en;
    bit          sink_idle_en;
    int          sink_hold;       // cycles the receiver must still hold off

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Truncating sum, computed bit for bit.
    function automatic logic [31:0] trunc_sum(logic [31:0] a, logic [31:0] b);
        logic        opp;
        logic [31:0] mag_a, mag_b, big, sml, dexp, bigf, smlf, frac, ex;
        opp   = a[31] != b[31];
        mag_a = a << 1;
        mag_b = b << 1;
        if (opp && mag_a == mag_b)
            return 32'h0;
        if (mag_b > mag_a)
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        ex   = {24'h0, big[30:23]};
        dexp = ex - {24'h0, sml[30:23]};
        if (dexp[31:1] == 31'd0 && opp)
        begin
            bigf = (big << 8) | SIGN_MASK;
            smlf = (sml << 8) | SIGN_MASK;
            if (dexp != 32'd0)
                smlf = smlf >> 1;
            frac = bigf - smlf;
            for (int k = 0; k < 32 && !frac[31]; k++)
            begin
                ex   = ex - 32'd1;
                frac = frac << 1;
            end
            frac = frac << 1;
        end
        else
        begin
            bigf = ((big << 8) | SIGN_MASK) >> 1;
            smlf = ((sml << 8) | SIGN_MASK) >> 1;
            smlf = (dexp >= 32'd32) ? 32'h0 : smlf >> dexp;
            smlf = smlf & ALIGN_MASK;
            frac = opp ? bigf - smlf : bigf + smlf;
            if (frac[31])
            begin
                frac = frac << 1;
                ex   = ex + 32'd1;
            end
            else if (frac[30])
                frac = frac << 2;
            else
            begin
                frac = frac << 3;
                ex   = ex - 32'd1;
            end
        end
        if ((sml << 1) == 32'd0)
            return big;
        return (big & SIGN_MASK) | (ex << 23) | (frac >> 9);
    endfunction

    // Offer one request; random gaps before it when idling is on.
    // tvalid stays high after acceptance so back-to-back requests need no gap.
    task automatic send_add(logic [31:0] a, logic [31:0] b);
        while (src_idle_en && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sum_queue.push_back(trunc_sum(a, b));
    endtask

    // Receiver readiness, including the long forced hold-off.
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 32);
    end

    // Result checker against the oldest pending sum.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sum_queue.size() == 0)
            begin
                $display("%0t: unexpected sum, expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                logic [31:0] want;
                want = sum_queue.pop_front();
                if (want !== m_axis_tdata)
                begin
                    $display("%0t: sum_bits mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    errors++;
                end
                sums_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 200000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sum_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(5))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[30:0]  = 31'h0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_special_cases();
        send_add(32'h3F80_0000, 32'hBF80_0000);  // exact cancellation
        send_add(32'h4040_0000, 32'h0000_0000);  // zero smaller operand
        send_add(32'h8000_0000, 32'hC120_0000);  // negative zero smaller
        send_add(32'h0000_0000, 32'h8000_0000);  // both zeros, opposite signs
        send_add(32'h3F80_0001, 32'hBF80_0000);  // near path, same exponent
        send_add(32'h4000_0000, 32'hBFFF_FFFF);  // near path, diff one
        send_add(32'h3F80_0000, 32'h3F80_0000);  // far add, carry out
        send_add(32'h4000_0000, 32'hBF00_0000);  // far sub, diff two
        send_add(32'h7F00_0000, 32'h0080_0000);  // huge shift, aligned away
        send_add(32'h7FFF_FFFF, 32'h7FFF_FFFF);  // exponent wrap upward
        send_add(32'h0080_0000, 32'h8000_0001);  // exponent wrap downward
        send_add(32'hFFFF_FFFF, 32'h0000_0001);
        send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_add(32'h0000_0001, 32'h0000_0001);
        send_add(32'h4B00_0000, 32'h3F80_003F);  // low bits cleared by align
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [31:0] a, b;
        for (int i = 0; i < n; i++)
        begin
            a = rand_fp();
            b = rand_fp();
            // bias toward close exponents to exercise near/far paths
            if ($urandom_range(1))
                b[30:23] = a[30:23] + 8'($urandom_range(0, 3)) - 8'd1;
            send_add(a, b);
        end
    endtask

    task automatic test_backpressure();
        sink_hold <= 60;
        src_idle_en = 1'b0;
        test_random(40);
        src_idle_en = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        errors        = 0;
        sums_checked  = 0;
        cycles        = 0;
        sink_hold     = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 64'h0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_random(500);
        // stretch with no idling on either side
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random(300);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_backpressure();
        test_random(500);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("checked %0d sums: special cases, random operands, stalls", sums_checked);
        if (errors == 0 && sum_queue.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
